### hdl/rmsod_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsod_pkg
// Shared types and constants for the running mean / deviation outlier
// detector: channel payloads, queue entry, operation and class codes.
// ----------------------------------------------------------------------------
package rmsod_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int COUNT_OUT_BITS = 16;

   // deviation limit register
   localparam int LIMIT_BITS    = 4;
   localparam int LIMIT_SQ_BITS = 2 * LIMIT_BITS;
   localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET    = LIMIT_BITS'(2);
   localparam logic [LIMIT_SQ_BITS-1:0] LIMIT_SQ_RESET =
      LIMIT_SQ_BITS'(LIMIT_RESET) * LIMIT_SQ_BITS'(LIMIT_RESET);

   // register port
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEVIATION_LIMIT = CSR_INDEX_BITS'(0);

   // sticky flag positions
   localparam int FLAG_NAN     = 0;
   localparam int FLAG_POS_INF = 1;
   localparam int FLAG_NEG_INF = 2;
   localparam int FLAG_BITS    = 3;

   typedef enum logic {
      OP_TRAIN = 1'b0,
      OP_QUERY = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      CLASS_FINITE  = 2'd0,
      CLASS_NAN     = 2'd1,
      CLASS_POS_INF = 2'd2,
      CLASS_NEG_INF = 2'd3
   } value_class_type;

   // what the back end has to do with a queued item
   typedef enum logic [1:0] {
      KIND_TRAIN_FINITE  = 2'd0,
      KIND_TRAIN_SPECIAL = 2'd1,
      KIND_QUERY_FINITE  = 2'd2,
      KIND_QUERY_SPECIAL = 2'd3
   } item_kind_type;

   typedef struct packed {
      operation_type                 operation;
      value_class_type               value_class;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic                      accepted;
      logic                      nan_permitted;
      logic                      pos_inf_permitted;
      logic                      neg_inf_permitted;
      logic [COUNT_OUT_BITS-1:0] sample_count;
      logic                      count_full;
   } rsp_payload_type;

   typedef struct packed {
      item_kind_type                 kind;
      value_class_type               value_class;
      logic signed [SAMPLE_BITS-1:0] sample;
   } work_item_type;

   typedef struct packed {
      logic          valid;
      work_item_type item;
   } queue_head_type;

endpackage
`default_nettype wire

### hdl/rmsod_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsod_front
// Input side: takes request beats, classifies each into a work kind and
// holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rmsod_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rmsod_pkg::req_payload_type req_payload,
   output rmsod_pkg::queue_head_type  head,
   input  logic                       head_pop
);
   import rmsod_pkg::*;

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   work_item_type       slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   work_item_type       item_in;
   logic                push;

   // classify the incoming beat
   always_comb begin
      item_in.value_class = req_payload.value_class;
      item_in.sample      = req_payload.sample;
      unique case (req_payload.operation)
         OP_TRAIN: begin
            item_in.kind = (req_payload.value_class == CLASS_FINITE) ?
                           KIND_TRAIN_FINITE : KIND_TRAIN_SPECIAL;
         end
         OP_QUERY: begin
            item_in.kind = (req_payload.value_class == CLASS_FINITE) ?
                           KIND_QUERY_FINITE : KIND_QUERY_SPECIAL;
         end
      endcase
   end

   // queue control
   assign req_stall = (count_ff == CNT_BITS'(DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");

endmodule
`default_nettype wire

### hdl/rmsod_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsod_back
// Execution side: keeps count, sum, sum of squares and the scaled variance,
// runs finite train and query items through one shared signed multiplier and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module rmsod_back #(
   parameter int COUNT_BITS = rmsod_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rmsod_pkg::queue_head_type            head,
   output logic                                 head_pop,
   input  logic [rmsod_pkg::LIMIT_SQ_BITS-1:0]  limit_sq,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rmsod_pkg::rsp_payload_type           rsp_payload
);
   import rmsod_pkg::*;

   localparam int SUM_W    = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W     = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
   localparam int SQ_LO_W  = (SQ_W + 1) / 2;
   localparam int VAR_W    = 2 * SAMPLE_BITS - 2 + 2 * COUNT_BITS;
   localparam int VAR_LO_W = (VAR_W + 1) / 2;
   localparam int OPND_W   = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int SQR_W    = 2 * (SAMPLE_BITS + COUNT_BITS);
   localparam int ACC_W    = VAR_W + LIMIT_SQ_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRAIN_LO,
      ST_TRAIN_HI,
      ST_TRAIN_VAR,
      ST_QUERY_SQ,
      ST_QUERY_KHI,
      ST_QUERY_KLO,
      ST_QUERY_CMP
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_BITS-1:0]     n_ff, n_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [VAR_W-1:0]          var_ff, var_in;
   logic [FLAG_BITS-1:0]      flags_ff, flags_in;
   logic signed [OPND_W-1:0]  d_ff, d_in;
   logic [SQR_W-1:0]          lhs_ff, lhs_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic signed [OPND_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      out_free;
   logic                      out_write;
   logic                      accepted;
   logic                      n_full;
   rsp_payload_type           out_data;

   // flag bit for a special value class
   function automatic logic [FLAG_BITS-1:0] class_mask(value_class_type cls);
      logic [FLAG_BITS-1:0] mask;
      unique case (cls)
         CLASS_NAN:     mask = FLAG_BITS'(1) << FLAG_NAN;
         CLASS_POS_INF: mask = FLAG_BITS'(1) << FLAG_POS_INF;
         CLASS_NEG_INF: mask = FLAG_BITS'(1) << FLAG_NEG_INF;
         CLASS_FINITE:  mask = '0;
      endcase
      return mask;
   endfunction

   assign n_full   = (n_ff == '1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            if (head.item.kind == KIND_QUERY_FINITE) begin
               mul_a = OPND_W'(n_ff);
            end else begin
               mul_a = OPND_W'(head.item.sample);
            end
            mul_b = OPND_W'(head.item.sample);
         end
         ST_TRAIN_LO: begin
            mul_a = OPND_W'(n_ff);
            mul_b = OPND_W'(sq_ff[SQ_LO_W-1:0]);
         end
         ST_TRAIN_HI: begin
            mul_a = OPND_W'(n_ff);
            mul_b = OPND_W'(sq_ff[SQ_W-1:SQ_LO_W]);
         end
         ST_TRAIN_VAR: begin
            mul_a = OPND_W'(sum_ff);
            mul_b = OPND_W'(sum_ff);
         end
         ST_QUERY_SQ: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         ST_QUERY_KHI: begin
            mul_a = OPND_W'(var_ff[VAR_W-1:VAR_LO_W]);
            mul_b = OPND_W'(limit_sq);
         end
         ST_QUERY_KLO: begin
            mul_a = OPND_W'(var_ff[VAR_LO_W-1:0]);
            mul_b = OPND_W'(limit_sq);
         end
         ST_QUERY_CMP: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // sequencer and datapath next values
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      var_in    = var_ff;
      flags_in  = flags_ff;
      d_in      = d_ff;
      lhs_in    = lhs_ff;
      acc_in    = acc_ff;
      head_pop  = 1'b0;
      out_write = 1'b0;
      accepted  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.item.kind)
                  KIND_TRAIN_SPECIAL: begin
                     if (out_free) begin
                        flags_in  = flags_ff | class_mask(head.item.value_class);
                        head_pop  = 1'b1;
                        out_write = 1'b1;
                     end
                  end
                  KIND_QUERY_SPECIAL: begin
                     if (out_free) begin
                        accepted  = |(flags_ff & class_mask(head.item.value_class));
                        head_pop  = 1'b1;
                        out_write = 1'b1;
                     end
                  end
                  KIND_TRAIN_FINITE: begin
                     if (n_full) begin
                        // saturated count: sample ignored
                        if (out_free) begin
                           head_pop  = 1'b1;
                           out_write = 1'b1;
                        end
                     end else begin
                        n_in     = n_ff + 1'b1;
                        sum_in   = sum_ff + SUM_W'(head.item.sample);
                        sq_in    = sq_ff + SQ_W'(unsigned'(prod));
                        if (n_ff == '0) begin
                           flags_in = '0;
                        end
                        head_pop = 1'b1;
                        state_in = ST_TRAIN_LO;
                     end
                  end
                  KIND_QUERY_FINITE: begin
                     if (n_ff == '0) begin
                        // no samples yet: only zero passes
                        if (out_free) begin
                           accepted  = (head.item.sample == '0);
                           head_pop  = 1'b1;
                           out_write = 1'b1;
                        end
                     end else begin
                        d_in     = prod[OPND_W-1:0] - OPND_W'(sum_ff);
                        head_pop = 1'b1;
                        state_in = ST_QUERY_SQ;
                     end
                  end
               endcase
            end
         end
         // n * sumsq in two halves, then minus sum^2
         ST_TRAIN_LO: begin
            acc_in   = ACC_W'(unsigned'(prod));
            state_in = ST_TRAIN_HI;
         end
         ST_TRAIN_HI: begin
            acc_in   = acc_ff + (ACC_W'(unsigned'(prod)) << SQ_LO_W);
            state_in = ST_TRAIN_VAR;
         end
         ST_TRAIN_VAR: begin
            if (out_free) begin
               var_in    = acc_ff[VAR_W-1:0] - VAR_W'(unsigned'(prod));
               out_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         // squared offset, then k^2 * variance in two halves
         ST_QUERY_SQ: begin
            lhs_in   = SQR_W'(unsigned'(prod));
            state_in = ST_QUERY_KHI;
         end
         ST_QUERY_KHI: begin
            acc_in   = ACC_W'(unsigned'(prod)) << VAR_LO_W;
            state_in = ST_QUERY_KLO;
         end
         ST_QUERY_KLO: begin
            acc_in   = acc_ff + ACC_W'(unsigned'(prod));
            state_in = ST_QUERY_CMP;
         end
         ST_QUERY_CMP: begin
            if (out_free) begin
               accepted  = (ACC_W'(lhs_ff) <= acc_ff);
               out_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
      endcase
   end

   // result beat from the post-item state
   always_comb begin
      out_data.accepted          = accepted;
      out_data.nan_permitted     = flags_in[FLAG_NAN];
      out_data.pos_inf_permitted = flags_in[FLAG_POS_INF];
      out_data.neg_inf_permitted = flags_in[FLAG_NEG_INF];
      out_data.sample_count      = COUNT_OUT_BITS'(n_in);
      out_data.count_full        = (n_in == '1);
   end

   // output register
   always_comb begin
      if (out_write) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = out_data;
      end else begin
         rsp_valid_in   = rsp_valid_ff && rsp_stall;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         var_ff       <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         var_ff       <= var_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff           <= d_in;
      lhs_ff         <= lhs_in;
      acc_ff         <= acc_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> n_ff >= $past(n_ff))
      else $error("sample count went down");

   a_first_sample_clears: assert property (@(posedge clock) disable iff (reset)
      (n_ff == COUNT_BITS'(1) && $past(n_ff) == '0) |-> flags_ff == '0)
      else $error("special flags survived first finite sample");

   a_leave_idle_on_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && $past(state_ff) == ST_IDLE) |-> $past(head_pop))
      else $error("sequencer started without taking a queue entry");

endmodule
`default_nettype wire

### hdl/running_mean_std_outlier_detector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_std_outlier_detector_top
// Running-statistics outlier detector: trains count, sum and sum of squares
// and answers whether a sample lies within k population deviations.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                           payload
//  req_*     in         req_valid / req_stall               req_payload_type
//  rsp_*     out        rsp_valid / rsp_stall               rsp_payload_type
//  csr_*     in/out     psel, penable, pwrite, pready       deviation_limit
//
//  finite train: states TRAIN_LO, TRAIN_HI, TRAIN_VAR; finite query: QUERY_SQ,
//  QUERY_KHI, QUERY_KLO, QUERY_CMP; special values, a saturated count or a query
//  with no samples: answered from idle. The steps share the one signed multiplier.
//  reset is synchronous: clears statistics, flags and queue; limit back to 2.
//  a two-entry queue takes beats while the back end works; a held result
//  stalls the back end, and the input stalls once both queue entries are taken.
// ----------------------------------------------------------------------------
module running_mean_std_outlier_detector_top #(
   parameter int COUNT_BITS = rmsod_pkg::COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rmsod_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rmsod_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rmsod_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rmsod_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rmsod_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import rmsod_pkg::*;

   logic [LIMIT_BITS-1:0]     limit_ff, limit_in;
   logic [LIMIT_SQ_BITS-1:0]  limit_sq_ff, limit_sq_in;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic                      csr_write;
   queue_head_type            head;
   logic                      head_pop;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_index == REG_DEVIATION_LIMIT);

   always_comb begin
      limit_in    = limit_ff;
      limit_sq_in = limit_sq_ff;
      if (csr_write) begin
         limit_in    = csr_pwdata[LIMIT_BITS-1:0];
         limit_sq_in = LIMIT_SQ_BITS'(csr_pwdata[LIMIT_BITS-1:0]) *
                       LIMIT_SQ_BITS'(csr_pwdata[LIMIT_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         limit_sq_ff <= LIMIT_SQ_RESET;
      end else begin
         limit_ff    <= limit_in;
         limit_sq_ff <= limit_sq_in;
      end
   end

   assign csr_prdata = (csr_index == REG_DEVIATION_LIMIT) ?
                       CSR_DATA_BITS'(limit_ff) : '0;

   // front end: classify and queue
   rmsod_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .head_pop    (head_pop)
   );

   // back end: statistics and test
   rmsod_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_pop    (head_pop),
      .limit_sq    (limit_sq_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
